// ===== src/irm_pkg.sv =====
package irm_pkg;

    // operation codes
    localparam logic [4:0] OP_NOOP = 5'd0;
    localparam logic [4:0] OP_END  = 5'd1;
    localparam logic [4:0] OP_ADD  = 5'd2;
    localparam logic [4:0] OP_SUB  = 5'd3;
    localparam logic [4:0] OP_MUL  = 5'd4;
    localparam logic [4:0] OP_DIV  = 5'd5;
    localparam logic [4:0] OP_MOD  = 5'd6;
    localparam logic [4:0] OP_AND  = 5'd7;
    localparam logic [4:0] OP_OR   = 5'd8;
    localparam logic [4:0] OP_XOR  = 5'd9;
    localparam logic [4:0] OP_NOT  = 5'd10;
    localparam logic [4:0] OP_SHL  = 5'd11;
    localparam logic [4:0] OP_SHR  = 5'd12;
    localparam logic [4:0] OP_ISEQ = 5'd13;
    localparam logic [4:0] OP_ISGT = 5'd14;
    localparam logic [4:0] OP_ISGE = 5'd15;
    localparam logic [4:0] OP_GOTO = 5'd16;
    localparam logic [4:0] OP_IF   = 5'd17;
    localparam logic [4:0] OP_SET  = 5'd18;
    localparam logic [4:0] OP_LDI  = 5'd19;

    localparam logic [31:0] HALT_PC = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [4:0]         operation;
        logic [4:0]         dest_reg;
        logic [4:0]         first_reg;
        logic [4:0]         second_reg;
        logic signed [31:0] immediate;
    } t_in_s;

    typedef struct packed {
        logic signed [31:0] next_pc;
        logic               wrote;
        logic signed [31:0] write_value;
        logic               halted;
        logic               fault;
    } t_out_s;

endpackage

// ===== src/irm_ram.sv =====
module irm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read during write to the same address returns the old word
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/int_register_machine_execute_unit.sv =====
// channel   signals                                      direction
// request   i_in_valid / o_in_ready / i_in_data        into the unit
// result    o_out_valid / i_out_ready / o_out_data     out of the unit
//
// Register file sits in two copies of a RAM with registered read, one per source.
// Simple operations: RAM read, then result register; one request per cycle while
// the output is free (execute write-back is forwarded to the read started with it).
// mul, div, mod (and shifts when DATA_WIDTH is not a power of two) run on one
// shared bit-serial unit, which takes no next request until its result is registered.
// Reset clears the counter and per-register valid bits; the RAMs are not swept.
// A full result register stalls execute and blocks further requests.
module int_register_machine_execute_unit #(
    parameter int NUM_REGS   = 32,
    parameter int DATA_WIDTH = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  irm_pkg::t_in_s i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output irm_pkg::t_out_s o_out_data
);
    import irm_pkg::*;

    localparam int  DW   = DATA_WIDTH;
    localparam int  AW   = $clog2(NUM_REGS);
    localparam int  SW   = $clog2(DW);
    localparam int  CW   = $clog2(DW + 1);
    localparam bit  POW2 = ((DW & (DW - 1)) == 0);

    typedef enum logic [1:0] {S_IDLE, S_EXEC, S_ITER} t_state;

    t_state          r_state;
    logic [31:0]     r_pc;
    logic [NUM_REGS-1:0] r_vld;
    logic [4:0]      r_op;
    logic [AW-1:0]   r_dst;
    logic signed [31:0] r_imm;
    logic            r_vld1, r_vld2, r_fwd1, r_fwd2;
    logic [DW-1:0]   r_fwd_data;
    logic [DW-1:0]   r_acc, r_opa, r_opb, r_aval;
    logic [CW-1:0]   r_cnt;
    logic            r_neg_q, r_neg_r;
    t_out_s          r_out;
    logic            r_out_valid;

    logic [AW-1:0]   idx_mod [32];
    logic [AW-1:0]   s1_idx, s2_idx;
    logic [DW-1:0]   q1, q2, a, b, ma, mb, v;
    logic [DW-1:0]   sh_src, shl_v, shr_v;
    logic [SW-1:0]   sh_amt;
    logic [63:0]     imm64, v64;
    logic [31:0]     pc_inc, npc_seq, npc_tgt, npc;
    logic            wr, flt, go_iter, out_free, in_acc, finish, wr_en;
    logic [DW:0]     rem_sh, diff;
    t_out_s          res;

    // register index modulo NUM_REGS
    for (genvar g = 0; g < 32; g++) begin : g_mod
        assign idx_mod[g] = AW'(g % NUM_REGS);
    end

    assign s1_idx   = idx_mod[i_in_data.first_reg];
    assign s2_idx   = idx_mod[i_in_data.second_reg];
    assign out_free = !r_out_valid || i_out_ready;
    assign o_in_ready = out_free &&
                        (r_state == S_IDLE || (r_state == S_EXEC && !go_iter));
    assign in_acc   = i_in_valid && o_in_ready;
    assign finish   = out_free && ((r_state == S_EXEC && !go_iter) ||
                                   (r_state == S_ITER && r_cnt == '0));
    assign wr_en    = finish && wr;

    irm_ram #(.WIDTH(DW), .DEPTH(NUM_REGS)) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_dst),
        .i_wdata (v),
        .i_re    (in_acc),
        .i_raddr (s1_idx),
        .o_rdata (q1)
    );

    irm_ram #(.WIDTH(DW), .DEPTH(NUM_REGS)) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_dst),
        .i_wdata (v),
        .i_re    (in_acc),
        .i_raddr (s2_idx),
        .o_rdata (q2)
    );

    assign a = r_fwd1 ? r_fwd_data : (r_vld1 ? q1 : '0);
    assign b = r_fwd2 ? r_fwd_data : (r_vld2 ? q2 : '0);
    assign ma = a[DW-1] ? (~a + DW'(1)) : a;
    assign mb = b[DW-1] ? (~b + DW'(1)) : b;

    // shifter shared by the direct and the iterated paths
    assign sh_src = (r_state == S_ITER) ? r_aval : a;
    assign sh_amt = (r_state == S_ITER) ? r_acc[SW-1:0] : b[SW-1:0];
    assign shl_v  = sh_src << sh_amt;
    assign shr_v  = $signed(sh_src) >>> sh_amt;

    assign imm64   = 64'(r_imm);
    assign pc_inc  = r_pc + 32'd1;
    assign npc_seq = pc_inc[31] ? HALT_PC : pc_inc;
    assign npc_tgt = r_imm[31] ? HALT_PC : r_imm;

    // one restoring-division step
    assign rem_sh = {r_acc, r_opb[DW-1]};
    assign diff   = rem_sh - {1'b0, r_opa};

    always_comb begin
        v       = '0;
        wr      = 1'b0;
        flt     = 1'b0;
        npc     = npc_seq;
        go_iter = 1'b0;
        if (r_state == S_ITER) begin
            wr = 1'b1;
            case (r_op)
                OP_MUL:  v = r_acc;
                OP_DIV:  v = r_neg_q ? (~r_opb + DW'(1)) : r_opb;
                OP_MOD:  v = r_neg_r ? (~r_acc + DW'(1)) : r_acc;
                OP_SHL:  v = shl_v;
                default: v = shr_v;
            endcase
        end else if (r_pc[31]) begin
            npc = HALT_PC;
        end else begin
            case (r_op)
                OP_NOOP: ;
                OP_END:  npc = HALT_PC;
                OP_ADD:  begin v = a + b; wr = 1'b1; end
                OP_SUB:  begin v = a - b; wr = 1'b1; end
                OP_MUL:  go_iter = 1'b1;
                OP_DIV, OP_MOD: begin
                    if (b == '0) begin
                        flt = 1'b1;
                        npc = HALT_PC;
                    end else begin
                        go_iter = 1'b1;
                    end
                end
                OP_AND:  begin v = a & b; wr = 1'b1; end
                OP_OR:   begin v = a | b; wr = 1'b1; end
                OP_XOR:  begin v = a ^ b; wr = 1'b1; end
                OP_NOT:  begin v = ~a; wr = 1'b1; end
                OP_SHL:  begin v = shl_v; wr = POW2; go_iter = !POW2; end
                OP_SHR:  begin v = shr_v; wr = POW2; go_iter = !POW2; end
                OP_ISEQ: begin v = (a == b) ? DW'(1) : '0; wr = 1'b1; end
                OP_ISGT: begin v = ($signed(a) > $signed(b)) ? DW'(1) : '0; wr = 1'b1; end
                OP_ISGE: begin v = ($signed(a) >= $signed(b)) ? DW'(1) : '0; wr = 1'b1; end
                OP_GOTO: npc = npc_tgt;
                OP_IF:   if (a != '0) npc = npc_tgt;
                OP_SET:  begin v = a; wr = 1'b1; end
                OP_LDI:  begin v = imm64[DW-1:0]; wr = 1'b1; end
                default: begin flt = 1'b1; npc = HALT_PC; end
            endcase
        end
    end

    assign v64 = 64'(v);

    always_comb begin
        res.next_pc     = npc;
        res.wrote       = wr;
        res.write_value = wr ? v64[31:0] : '0;
        res.halted      = npc[31];
        res.fault       = flt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pc        <= '0;
            r_vld       <= '0;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            if (in_acc) begin
                r_op       <= i_in_data.operation;
                r_dst      <= idx_mod[i_in_data.dest_reg];
                r_imm      <= i_in_data.immediate;
                r_vld1     <= r_vld[s1_idx];
                r_vld2     <= r_vld[s2_idx];
                r_fwd1     <= wr_en && (r_dst == s1_idx);
                r_fwd2     <= wr_en && (r_dst == s2_idx);
                r_fwd_data <= v;
            end

            if (wr_en) begin
                r_vld[r_dst] <= 1'b1;
            end

            if (finish) begin
                r_pc        <= npc;
                r_out       <= res;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_acc) r_state <= S_EXEC;
                end
                S_EXEC: begin
                    if (go_iter) begin
                        r_state <= S_ITER;
                        r_cnt   <= CW'(DW);
                        r_acc   <= '0;
                        r_aval  <= a;
                        r_neg_q <= a[DW-1] ^ b[DW-1];
                        r_neg_r <= a[DW-1];
                        if (r_op == OP_MUL) begin
                            r_opa <= a;
                            r_opb <= b;
                        end else if (r_op == OP_DIV || r_op == OP_MOD) begin
                            r_opa <= mb;
                            r_opb <= ma;
                        end else begin
                            // shift amount = b mod DATA_WIDTH via the divider
                            r_opa <= DW'(DW);
                            r_opb <= b;
                        end
                    end else if (out_free) begin
                        r_state <= in_acc ? S_EXEC : S_IDLE;
                    end
                end
                S_ITER: begin
                    if (r_cnt != '0) begin
                        r_cnt <= r_cnt - CW'(1);
                        if (r_op == OP_MUL) begin
                            if (r_opb[0]) r_acc <= r_acc + r_opa;
                            r_opa <= r_opa << 1;
                            r_opb <= r_opb >> 1;
                        end else begin
                            r_acc <= diff[DW] ? rem_sh[DW-1:0] : diff[DW-1:0];
                            r_opb <= {r_opb[DW-2:0], !diff[DW]};
                        end
                    end else if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
